// File: sv/srbr_pkg.sv
// Shared constants, types and helpers for the segment ring byte reader.
// No dependencies; imported by every module of the block but srbr_ram.
`timescale 1ns / 1ps
`default_nettype none

package srbr_pkg;

	localparam int DEPTH        = 16;
	localparam int HANDLE_WIDTH = 16;
	localparam int PIECE_LIMIT  = 16;

	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int N_W     = $clog2(PIECE_LIMIT + 1);
	localparam int BYTES_W = 20;
	localparam int LEN_W   = 16;
	localparam int LG_W    = 3;
	localparam int LG_RESET = 4;

	// request modes
	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_PEEK  = 2'd2;
	localparam logic [1:0] MODE_DRAIN = 2'd3;

	// result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// register index (byte address bit 2)
	localparam logic REG_RING_SIZE_LOG2 = 1'b0;

	typedef struct packed {
		logic [HANDLE_WIDTH-1:0] handle;
		logic [LEN_W-1:0]        remaining;
		logic [LEN_W-1:0]        trim;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic accept;
		logic walk_a;   // counting pass of a read
		logic walk_b;   // emitting pass of a read, or a peek
	} dp_cmd_t;

	typedef struct packed {
		logic walk_req;
		logic peek_req;
		logic walk_last;
	} dp_stat_t;

	// slots in use: 2^lg, capped at DEPTH
	function automatic logic [CNT_W-1:0] ring_cap(input logic [LG_W-1:0] lg);
		int c;
		c = 1 << lg;
		if (c > DEPTH)
			c = DEPTH;
		return CNT_W'(c);
	endfunction

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] inc;
		inc = {1'b0, CNT_W'(i)} + 1'b1;
		return (inc >= {1'b0, cap}) ? '0 : IDX_W'(inc);
	endfunction

endpackage

`default_nettype wire

// File: sv/srbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module srbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/srbr_regs.sv
// APB-style register file: ring_size_log2 at byte address 0.
// Depends on srbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srbr_regs
	import srbr_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [2:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic      [31:0]     prdata,
	output logic                 pready,
	output logic      [LG_W-1:0] ring_lg,
	output logic                 ring_wr
);

	logic [LG_W-1:0] lg_q;
	logic            sel_lg;

	assign sel_lg  = (paddr[2] == REG_RING_SIZE_LOG2);
	assign pready  = 1'b1;
	assign ring_wr = psel && penable && pwrite && sel_lg;
	assign ring_lg = lg_q;
	assign prdata  = sel_lg ? {{(32 - LG_W){1'b0}}, lg_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= LG_W'(LG_RESET);
		end else if (ring_wr) begin
			lg_q <= pwdata[LG_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: sv/srbr_ctrl.sv
// Controller: idle, counting pass and emitting pass of a read or peek walk.
// Depends on srbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srbr_ctrl
	import srbr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK_A = 2'd1;
	localparam logic [1:0] S_WALK_B = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd.accept = start && (state_q == S_IDLE);
		cmd.walk_a = (state_q == S_WALK_A);
		cmd.walk_b = (state_q == S_WALK_B);
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && stat.walk_req)
					state_d = stat.peek_req ? S_WALK_B : S_WALK_A;
			end
			S_WALK_A: begin
				if (stat.walk_last)
					state_d = S_WALK_B;
			end
			S_WALK_B: begin
				if (stat.walk_last)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/srbr_datapath.sv
// Datapath: ring pointers, byte count, slot walk and result registers.
// Depends on srbr_pkg and srbr_ram.
`timescale 1ns / 1ps
`default_nettype none

module srbr_datapath
	import srbr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_stat_t                stat,
	input  wire logic [LG_W-1:0]    ring_lg,
	input  wire logic               ring_wr,
	input  wire logic [1:0]         mode,
	input  wire logic [15:0]        segment_handle,
	input  wire logic [15:0]        segment_length,
	input  wire logic [19:0]        request_bytes,
	output logic                    result_strobe,
	output logic      [1:0]         status,
	output logic      [15:0]        piece_handle,
	output logic      [15:0]        piece_offset,
	output logic      [15:0]        piece_length,
	output logic                    release_res,
	output logic                    last_piece,
	output logic      [4:0]         free_slots,
	output logic      [19:0]        available_bytes
);

	// ring state
	logic [IDX_W-1:0]   head_q, tail_q;
	logic [CNT_W-1:0]   count_q;
	logic [BYTES_W-1:0] bytes_q;

	// walk state
	logic [IDX_W-1:0]   idx_q;
	logic [BYTES_W-1:0] want_q, want_init_q, taken_q;
	logic [CNT_W-1:0]   walked_q;
	logic [N_W-1:0]     n_q;
	logic               peek_q;
	logic [CNT_W-1:0]   fin_free_q;
	logic [BYTES_W-1:0] fin_avail_q;

	// result registers
	logic               strobe_q;
	logic [1:0]         status_q;
	logic [15:0]        handle_q, offset_q, length_q;
	logic               release_q, last_q;
	logic [4:0]         free_q;
	logic [19:0]        avail_q;

	// combinational
	logic [CNT_W-1:0]   cap;
	logic [BYTES_W-1:0] want0;
	logic               full;
	slot_t              rd, wr;
	logic [SLOT_W-1:0]  ram_rdata;
	logic [LEN_W-1:0]   sz;
	logic               whole;
	logic [BYTES_W-1:0] want_n, taken_n;
	logic [CNT_W-1:0]   walked_n;
	logic [N_W-1:0]     n_n;
	logic [IDX_W-1:0]   idx_n, raddr, waddr;
	logic               walking, last, push_ok, trim_wr;
	logic [HANDLE_WIDTH-1:0]    in_handle;
	logic [HANDLE_WIDTH+15:0]   hnd_in_ext;
	logic [HANDLE_WIDTH+15:0]   hnd_out_ext;

	assign cap        = ring_cap(ring_lg);
	assign full       = (count_q >= cap);
	assign want0      = (request_bytes > bytes_q) ? bytes_q : request_bytes;
	assign hnd_in_ext = {{HANDLE_WIDTH{1'b0}}, segment_handle};
	assign in_handle  = hnd_in_ext[HANDLE_WIDTH-1:0];

	assign rd          = slot_t'(ram_rdata);
	assign hnd_out_ext = {16'b0, rd.handle};

	always_comb begin
		sz       = (want_q < {{(BYTES_W - LEN_W){1'b0}}, rd.remaining})
			? want_q[LEN_W-1:0] : rd.remaining;
		whole    = (sz == rd.remaining);
		want_n   = want_q - {{(BYTES_W - LEN_W){1'b0}}, sz};
		taken_n  = taken_q + {{(BYTES_W - LEN_W){1'b0}}, sz};
		walked_n = walked_q + {{(CNT_W - 1){1'b0}}, whole};
		n_n      = n_q + 1'b1;
		idx_n    = whole ? next_idx(idx_q, cap) : idx_q;
		last     = !(whole && (want_n != '0) && (walked_n < count_q)
			&& (n_n < N_W'(PIECE_LIMIT)));
		walking  = cmd.walk_a || cmd.walk_b;
		// idle: keep the head prefetched; walking: fetch the next slot
		raddr    = (walking && !last) ? idx_n : head_q;
		push_ok  = cmd.accept && (mode == MODE_PUSH) && !full;
		trim_wr  = cmd.walk_b && last && !peek_q && !whole;
		waddr    = push_ok ? tail_q : idx_q;
		if (push_ok) begin
			wr.handle    = in_handle;
			wr.remaining = segment_length;
			wr.trim      = '0;
		end else begin
			wr.handle    = rd.handle;
			wr.remaining = rd.remaining - sz;
			wr.trim      = rd.trim + sz;
		end
	end

	assign stat = '{
		walk_req:  ((mode == MODE_READ) || (mode == MODE_PEEK)) && (want0 != '0),
		peek_req:  (mode == MODE_PEEK),
		walk_last: last
	};

	srbr_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (push_ok || trim_wr),
		.waddr (waddr),
		.wdata (wr),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			bytes_q <= '0;
		end else if (ring_wr) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			bytes_q <= '0;
		end else if (push_ok) begin
			tail_q  <= next_idx(tail_q, cap);
			count_q <= count_q + 1'b1;
			bytes_q <= bytes_q + {{(BYTES_W - LEN_W){1'b0}}, segment_length};
		end else if (cmd.accept && (mode == MODE_DRAIN)) begin
			head_q  <= tail_q;
			count_q <= '0;
			bytes_q <= '0;
		end else if (cmd.walk_b && last && !peek_q) begin
			head_q  <= idx_n;
			count_q <= count_q - walked_n;
			bytes_q <= bytes_q - taken_n;
		end
	end

	// walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peek_q      <= 1'b0;
			idx_q       <= '0;
			want_q      <= '0;
			want_init_q <= '0;
			taken_q     <= '0;
			walked_q    <= '0;
			n_q         <= '0;
			fin_free_q  <= '0;
			fin_avail_q <= '0;
		end else if (cmd.accept) begin
			peek_q      <= (mode == MODE_PEEK);
			idx_q       <= head_q;
			want_q      <= want0;
			want_init_q <= want0;
			taken_q     <= '0;
			walked_q    <= '0;
			n_q         <= '0;
			fin_free_q  <= cap - count_q;
			fin_avail_q <= bytes_q;
		end else if (cmd.walk_a && last) begin
			// end of counting pass: rewind for the emitting pass
			fin_free_q  <= cap - (count_q - walked_n);
			fin_avail_q <= bytes_q - taken_n;
			idx_q       <= head_q;
			want_q      <= want_init_q;
			taken_q     <= '0;
			walked_q    <= '0;
			n_q         <= '0;
		end else if (walking) begin
			idx_q    <= idx_n;
			want_q   <= want_n;
			taken_q  <= taken_n;
			walked_q <= walked_n;
			n_q      <= n_n;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q  <= 1'b0;
			status_q  <= ST_OK;
			handle_q  <= '0;
			offset_q  <= '0;
			length_q  <= '0;
			release_q <= 1'b0;
			last_q    <= 1'b0;
			free_q    <= '0;
			avail_q   <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.accept && !stat.walk_req) begin
				strobe_q  <= 1'b1;
				handle_q  <= '0;
				offset_q  <= '0;
				length_q  <= '0;
				release_q <= 1'b0;
				last_q    <= 1'b1;
				unique case (mode)
					MODE_PUSH: begin
						status_q <= full ? ST_FULL : ST_OK;
						free_q   <= full ? 5'(cap - count_q) : 5'(cap - count_q - 1'b1);
						avail_q  <= full ? bytes_q
							: bytes_q + {{(BYTES_W - LEN_W){1'b0}}, segment_length};
					end
					MODE_DRAIN: begin
						status_q <= ST_OK;
						free_q   <= 5'(cap);
						avail_q  <= '0;
					end
					default: begin
						status_q <= ST_EMPTY;
						free_q   <= 5'(cap - count_q);
						avail_q  <= bytes_q;
					end
				endcase
			end else if (cmd.walk_b) begin
				strobe_q  <= 1'b1;
				status_q  <= ST_OK;
				handle_q  <= hnd_out_ext[15:0];
				offset_q  <= rd.trim;
				length_q  <= sz;
				release_q <= !peek_q && whole;
				last_q    <= last;
				free_q    <= 5'(fin_free_q);
				avail_q   <= fin_avail_q;
			end
		end
	end

	assign result_strobe   = strobe_q;
	assign status          = status_q;
	assign piece_handle    = handle_q;
	assign piece_offset    = offset_q;
	assign piece_length    = length_q;
	assign release_res     = release_q;
	assign last_piece      = last_q;
	assign free_slots      = free_q;
	assign available_bytes = avail_q;

endmodule

`default_nettype wire

// File: sv/segment_ring_byte_reader_top.sv
// Top level of the segment ring byte reader: register file, controller, datapath.
// Depends on srbr_pkg, srbr_regs, srbr_ctrl, srbr_datapath (and srbr_ram below it).
//
// Usage:
//  - Requests: drive mode and its fields with start high; a request is taken
//    at a rising edge where start is high and busy is low.
//  - Push (0) stores a segment descriptor, or is rejected when the ring is full.
//    Drain (3) drops every pending segment. Both give one result.
//  - Read (1) and peek (2) walk the ring from the head and give one result per
//    segment touched (at most 16), last_piece marking the final one. A read
//    that finds nothing to take gives one result with status 2.
//  - Results appear on the result ports for one cycle with result_strobe high.
//    The receiver cannot stall: every result must be taken as it comes.
//  - Latency: push, drain and empty reads give their result in the cycle after
//    the request, and busy never rises; a new request may follow at once.
//  - Peek of n pieces: the request moves the controller state register into the
//    emitting pass, which gives the pieces one per cycle through the result
//    registers; the last shows in the cycle busy falls. Read of n pieces: a
//    counting pass walks the slots to learn the final free and byte counts that
//    every piece carries, then the emitting pass gives the n pieces one per cycle.
//    The walk rate is set by the single read port of the slot RAM.
//  - Configuration: ring_size_log2 at address 0; a write empties the ring.
//    Write it only while busy is low and no result is pending.
//  - Reset: ring empty, ring_size_log2 = 4, no result pending. Slot RAM has no
//    reset; only slots that were pushed are ever read.
`timescale 1ns / 1ps
`default_nettype none

module segment_ring_byte_reader_top
	import srbr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] segment_handle,
	input  wire logic [15:0] segment_length,
	input  wire logic [19:0] request_bytes,
	// result channel
	output logic             result_strobe,
	output logic      [1:0]  status,
	output logic      [15:0] piece_handle,
	output logic      [15:0] piece_offset,
	output logic      [15:0] piece_length,
	output logic             release_res,
	output logic             last_piece,
	output logic      [4:0]  free_slots,
	output logic      [19:0] available_bytes,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	logic [LG_W-1:0] ring_lg;
	logic            ring_wr;
	dp_cmd_t         cmd;
	dp_stat_t        stat;

	srbr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ring_lg (ring_lg),
		.ring_wr (ring_wr)
	);

	// sequencing of the two walk passes
	srbr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// pointers, byte count, slot RAM and result registers
	srbr_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.ring_lg         (ring_lg),
		.ring_wr         (ring_wr),
		.mode            (mode),
		.segment_handle  (segment_handle),
		.segment_length  (segment_length),
		.request_bytes   (request_bytes),
		.result_strobe   (result_strobe),
		.status          (status),
		.piece_handle    (piece_handle),
		.piece_offset    (piece_offset),
		.piece_length    (piece_length),
		.release_res     (release_res),
		.last_piece      (last_piece),
		.free_slots      (free_slots),
		.available_bytes (available_bytes)
	);

	// a walk ends only with its final piece
	a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_strobe && last_piece))
		else $error("busy dropped without a final piece");

	// a non-final piece means the walk is still running
	a_mid_piece_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_piece) |-> busy)
		else $error("non-final piece outside a walk");

	// error results are always single
	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && (status != ST_OK)) |-> last_piece)
		else $error("error result not marked last");

	// release only on successful read pieces
	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && release_res) |-> (status == ST_OK))
		else $error("release on a failed result");

endmodule

`default_nettype wire

// File: tb/segment_ring_byte_reader_top_test.sv
// Self-checking bench for segment_ring_byte_reader_top: directed and random requests,
// each result compared against a built-in ring model. Depends on srbr_pkg and the RTL.
`timescale 1ns / 1ps

module segment_ring_byte_reader_top_test;
	import srbr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 40;	// covers the longest read: counting and emitting passes of 16 pieces

	// one result as the DUT presents it
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] handle;
		logic [15:0] offset;
		logic [15:0] length;
		logic        release_flag;
		logic        last;
		logic [4:0]  free;
		logic [19:0] avail;
	} piece_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = MODE_PUSH;
	logic [15:0] segment_handle = '0;
	logic [15:0] segment_length = '0;
	logic [19:0] request_bytes = '0;
	logic        result_strobe;
	logic [1:0]  status;
	logic [15:0] piece_handle;
	logic [15:0] piece_offset;
	logic [15:0] piece_length;
	logic        release_res;
	logic        last_piece;
	logic [4:0]  free_slots;
	logic [19:0] available_bytes;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// ring model: descriptor slots plus head/tail/occupancy and the byte count
	logic [15:0] ring_handle[DEPTH];
	logic [15:0] ring_left[DEPTH];
	logic [15:0] ring_trim[DEPTH];
	int unsigned ring_head, ring_tail, ring_used, ring_slots;
	logic [19:0] ring_bytes;

	piece_t pending_pieces[$];	// pieces predicted but not yet seen
	int     mismatch_count = 0;
	int     cycle_count = 0;
	int     send_idle_pct = 0;	// chance in 100 that the sender sits out a cycle

	segment_ring_byte_reader_top DUT (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .mode(mode),
		.segment_handle(segment_handle), .segment_length(segment_length),
		.request_bytes(request_bytes),
		.result_strobe(result_strobe), .status(status),
		.piece_handle(piece_handle), .piece_offset(piece_offset),
		.piece_length(piece_length), .release_res(release_res),
		.last_piece(last_piece), .free_slots(free_slots),
		.available_bytes(available_bytes),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("segment_ring_byte_reader_top test failed");
			$finish;
		end
	end

	// only the first ten problems are printed; the rest are just counted
	function automatic void flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endfunction

	// Any write of the size register empties the ring. Size is 2^lg, saturating at DEPTH.
	function automatic void ring_resize(logic [2:0] lg);
		ring_slots = 1;
		for (int i = 0; i < lg && ring_slots < DEPTH; i++)
			ring_slots = ring_slots * 2;
		ring_head = 0;
		ring_tail = 0;
		ring_used = 0;
		ring_bytes = '0;
	endfunction

	// Advance the ring model by one accepted request and queue the pieces it yields.
	// free/avail are post-step values and are stamped on every piece of the step.
	function automatic void predict_request(logic [1:0] m, logic [15:0] h, logic [15:0] len,
			logic [19:0] req);
		piece_t      walk[$];
		piece_t      p;
		logic [19:0] want, taken;
		logic [15:0] rem, sz;
		int unsigned idx, walked;
		bit          peek_only, whole;
		p = '0;
		case (m)
			MODE_PUSH: begin
				if (ring_used >= ring_slots) begin
					p.status = ST_FULL;
				end else begin
					ring_handle[ring_tail] = h;
					ring_left[ring_tail] = len;
					ring_trim[ring_tail] = '0;
					ring_tail = (ring_tail + 1 >= ring_slots) ? 0 : ring_tail + 1;
					ring_used++;
					ring_bytes = ring_bytes + len;
					p.status = ST_OK;
				end
				walk.push_back(p);
			end
			MODE_DRAIN: begin
				ring_head = ring_tail;
				ring_used = 0;
				ring_bytes = '0;
				p.status = ST_OK;
				walk.push_back(p);
			end
			default: begin
				peek_only = (m == MODE_PEEK);
				want = (req > ring_bytes) ? ring_bytes : req;
				if (want == 0) begin
					// nothing to take; zero-length segments stay where they are
					p.status = ST_EMPTY;
					walk.push_back(p);
				end else begin
					idx = ring_head;
					walked = 0;
					taken = '0;
					while (want != 0 && walked < ring_used && walk.size() < PIECE_LIMIT) begin
						rem = ring_left[idx];
						sz = (rem < want) ? rem : want[15:0];
						whole = (sz == rem);
						p = '0;
						p.status = ST_OK;
						p.handle = ring_handle[idx];
						p.offset = ring_trim[idx];
						p.length = sz;
						p.release_flag = !peek_only && whole;
						walk.push_back(p);
						want = want - sz;
						taken = taken + sz;
						// a cut segment stays at the head, trimmed
						if (!peek_only && !whole) begin
							ring_left[idx] = rem - sz;
							ring_trim[idx] = ring_trim[idx] + sz;
						end
						if (!whole)
							break;
						idx = (idx + 1 >= ring_slots) ? 0 : idx + 1;
						walked++;
					end
					if (!peek_only) begin
						ring_head = idx;
						ring_used = ring_used - walked;
						ring_bytes = ring_bytes - taken;
					end
				end
			end
		endcase
		foreach (walk[k]) begin
			walk[k].last = (k == walk.size() - 1);
			walk[k].free = 5'(ring_slots - ring_used);
			walk[k].avail = ring_bytes;
			pending_pieces.push_back(walk[k]);
		end
	endfunction

	// Results live one cycle; sample mid-cycle so nothing races the clock edge.
	always @(negedge clk) begin
		piece_t got, want;
		if (arst_n && result_strobe) begin
			got = '{status, piece_handle, piece_offset, piece_length, release_res,
				last_piece, free_slots, available_bytes};
			if (pending_pieces.size() == 0) begin
				flag_error($sformatf("unexpected result st=%0d h=%h off=%h len=%h",
					status, piece_handle, piece_offset, piece_length));
			end else begin
				want = pending_pieces.pop_front();
				if (got !== want)
					flag_error($sformatf({"result mismatch: expected st=%0d h=%h off=%h len=%h ",
						"rel=%0d last=%0d free=%0d avail=%h; got st=%0d h=%h off=%h len=%h ",
						"rel=%0d last=%0d free=%0d avail=%h"},
						want.status, want.handle, want.offset, want.length,
						want.release_flag, want.last, want.free, want.avail,
						got.status, got.handle, got.offset, got.length,
						got.release_flag, got.last, got.free, got.avail));
			end
		end
	end

	// Present one request and hold it until the DUT takes it (start high, busy low).
	// Called right after a rising edge; returns right after the accepting edge with
	// start still high, so a back-to-back request needs no low pulse.
	task automatic send_request(input logic [1:0] m, input logic [15:0] h,
			input logic [15:0] len, input logic [19:0] req);
		bit taken;
		taken = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		segment_handle <= h;
		segment_length <= len;
		request_bytes <= req;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		predict_request(m, h, len, req);
	endtask

	// Let every predicted piece come back, then give the walk time to wind down.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_pieces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of the size register, then a read-back. Only done with the block quiet.
	task automatic write_ring_size(input logic [2:0] lg, input logic [28:0] junk);
		bit          done;
		logic [31:0] rd;
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_RING_SIZE_LOG2, 2'b00};
		pwdata <= {junk, lg};	// upper bits are don't-care
		@(posedge clk);
		penable <= 1'b1;
		done = 0;
		while (!done) begin
			@(negedge clk);
			done = pready;
			@(posedge clk);
		end
		ring_resize(lg);
		// read-back: setup then access
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		done = 0;
		while (!done) begin
			@(negedge clk);
			done = pready;
			rd = prdata;
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== {29'd0, lg})
			flag_error($sformatf("ring_size_log2 read-back: expected %0d got %h", lg, rd));
	endtask

	// segment lengths: mostly short, with zero and full-width mixed in
	function automatic logic [15:0] rand_length();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 300));
		endcase
	endfunction

	function automatic logic [19:0] rand_request();
		case ($urandom_range(9))
			0: return 20'd0;
			1: return 20'hFFFFF;
			2: return 20'($urandom);
			3: return 20'($urandom_range(1, 16));
			default: return 20'($urandom_range(1, 600));
		endcase
	endfunction

	// Fill the ring one past capacity (last push rejected), then walk it all.
	// At 16 slots this hits the piece limit.
	task automatic fill_and_sweep();
		int room;
		room = ring_slots - ring_used;
		repeat (room + 1)
			send_request(MODE_PUSH, 16'($urandom), rand_length(), 20'($urandom));
		send_request($urandom_range(1) ? MODE_READ : MODE_PEEK, 16'($urandom),
			16'($urandom), 20'hFFFFF);
	endtask

	task automatic send_random_request();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			send_request(MODE_PUSH, 16'($urandom), rand_length(), 20'($urandom));
		else if (pick < 72)
			send_request(MODE_READ, 16'($urandom), 16'($urandom), rand_request());
		else if (pick < 87)
			send_request(MODE_PEEK, 16'($urandom), 16'($urandom), rand_request());
		else if (pick < 97)
			send_request(MODE_DRAIN, 16'($urandom), 16'($urandom), 20'($urandom));
		else
			fill_and_sweep();
	endtask

	// Read, peek and drain with nothing buffered.
	task automatic test_empty_ring();
		send_request(MODE_READ, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_request(MODE_PEEK, 16'h0000, 16'h0000, 20'hFFFFF);
		send_request(MODE_DRAIN, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_request(MODE_READ, 16'h0000, 16'h0000, 20'd0);
	endtask

	// Partial reads, trim offsets, zero-length segments and the empty clamp.
	task automatic test_segment_walk();
		send_request(MODE_PUSH, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
		send_request(MODE_PUSH, 16'h0000, 16'd0, 20'd0);
		send_request(MODE_PUSH, 16'h5A5A, 16'd1, 20'd0);
		send_request(MODE_PEEK, 16'd0, 16'd0, 20'hFFFFF);	// three pieces, no release
		send_request(MODE_READ, 16'd0, 16'd0, 20'h08000);	// cut first segment in half
		send_request(MODE_PEEK, 16'd0, 16'd0, 20'h0FFFF);	// offset now 0x8000
		send_request(MODE_READ, 16'd0, 16'd0, 20'h07FFF);	// exactly the rest
		send_request(MODE_READ, 16'd0, 16'd0, 20'd5);	// zero-length one released on the way
		send_request(MODE_PUSH, 16'hA5A5, 16'd0, 20'd0);
		send_request(MODE_READ, 16'd0, 16'd0, 20'd3);	// only zero bytes buffered: empty
		send_request(MODE_PEEK, 16'd0, 16'd0, 20'd1);
		send_request(MODE_DRAIN, 16'd0, 16'd0, 20'd0);	// drops the zero-length slot
		send_request(MODE_PUSH, 16'h1234, 16'd10, 20'd0);
		send_request(MODE_READ, 16'd0, 16'd0, 20'd0);	// zero request: empty
		send_request(MODE_READ, 16'd0, 16'd0, 20'hFFFFF);
	endtask

	// Smallest ring: second push is rejected.
	task automatic test_single_slot();
		write_ring_size(3'd0, 29'd0);
		send_request(MODE_PUSH, 16'hBEEF, 16'd7, 20'd0);
		send_request(MODE_PUSH, 16'hCAFE, 16'd9, 20'd0);
		send_request(MODE_READ, 16'd0, 16'd0, 20'hFFFFF);
		send_request(MODE_DRAIN, 16'd0, 16'd0, 20'd0);
	endtask

	task automatic test_random_traffic(input int steps, input int idle_pct,
			input logic [2:0] lg);
		write_ring_size(lg, 29'($urandom));
		send_idle_pct = idle_pct;
		repeat (steps) send_random_request();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		ring_resize(3'(LG_RESET));
		@(posedge clk);

		test_empty_ring();
		test_segment_walk();
		test_single_slot();

		// random phases: ring size and sender idling vary per phase
		test_random_traffic(80, 0, 3'd4);
		test_random_traffic(70, 86, 3'd2);
		test_random_traffic(80, 15, 3'd7);	// above range, saturates at DEPTH
		test_random_traffic(30, 0, 3'd0);
		test_random_traffic(40, 86, 3'd5);
		test_random_traffic(30, 0, 3'd1);
		test_random_traffic(30, 15, 3'd6);
		test_random_traffic(30, 0, 3'd3);

		wait_drained();
		if (mismatch_count == 0)
			$display("segment_ring_byte_reader_top test passed");
		else
			$display("segment_ring_byte_reader_top test failed");
		$finish;
	end

endmodule
